>>> hw/rtl/sff_pkg.sv
// Shared types and fixed widths for the symmetric FIR filter.
package sff_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int COEF_W     = 16;
	localparam int NCOEF      = 8;
	localparam int COEF_IDX_W = 3;
	localparam int CFG_IDX_W  = 4;
	localparam int PSUM_W     = SAMPLE_W + 1;
	localparam int PROD_W     = PSUM_W + COEF_W;
	localparam int NPAIR      = NCOEF / 2;
	localparam int PAIR_W     = PROD_W + 1;
	localparam int ACC_W      = PAIR_W + 2;
	localparam int FRAC_BITS  = 15;
	localparam int Q_W        = ACC_W - FRAC_BITS;
	localparam int ROUND_BIAS = 1 << (FRAC_BITS - 1);

	localparam logic signed [Q_W-1:0] SAT_MAX = Q_W'(32767);
	localparam logic signed [Q_W-1:0] SAT_MIN = -Q_W'(32768);
	localparam logic signed [SAMPLE_W-1:0] OUT_MAX = 16'sh7FFF;
	localparam logic signed [SAMPLE_W-1:0] OUT_MIN = 16'sh8000;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [COEF_W-1:0]   coef_t;
	typedef logic signed [PSUM_W-1:0]   psum_t;
	typedef logic signed [PROD_W-1:0]   prod_t;
	typedef logic signed [PAIR_W-1:0]   pair_t;
	typedef logic signed [ACC_W-1:0]    acc_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       start_req;
	} sample_req_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] filtered;
		logic                       clipped;
	} result_t;

	// Load enables for the arithmetic stages.
	typedef struct packed {
		logic en_s2;
		logic en_s3;
		logic en_s4;
	} sff_adv_t;

endpackage

>>> hw/rtl/sff_delay_line.sv
// Sample delay line and pre-adders that fold each mirrored tap pair.
module sff_delay_line import sff_pkg::*; #(
	parameter int TAPS = 15
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        accept,
	input  logic        load,
	input  sample_req_t req,
	output psum_t       psum_s1 [NCOEF]
);

	localparam int HALF = TAPS / 2;

	sample_t x [TAPS];
	psum_t   psum_d [NCOEF];

	assign x[0] = req.sample;

	if (TAPS > 1) begin : g_hist
		localparam int HLEN = TAPS - 1;
		sample_t hist_q [HLEN];

		// A start request makes every older sample count as zero for this item too.
		for (genvar i = 1; i < TAPS; i++) begin : g_tap
			assign x[i] = req.start_req ? '0 : hist_q[i-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				for (int i = 0; i < HLEN; i++) begin
					hist_q[i] <= '0;
				end
			end else if (accept) begin
				hist_q[0] <= req.sample;
				for (int i = 1; i < HLEN; i++) begin
					hist_q[i] <= req.start_req ? '0 : hist_q[i-1];
				end
			end
		end

		a_newest: assert property (@(posedge clk) disable iff (!arst_n)
			accept |=> hist_q[0] == $past(req.sample))
			else $error("delay line did not take the accepted sample");
	end

	for (genvar k = 0; k < NCOEF; k++) begin : g_lane
		if (k < HALF) begin : g_pair
			assign psum_d[k] = {x[k][SAMPLE_W-1], x[k]} +
				{x[TAPS-1-k][SAMPLE_W-1], x[TAPS-1-k]};
		end else if (k == HALF && (TAPS % 2) == 1) begin : g_mid
			assign psum_d[k] = {x[k][SAMPLE_W-1], x[k]};
		end else begin : g_zero
			assign psum_d[k] = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			for (int k = 0; k < NCOEF; k++) begin
				psum_s1[k] <= psum_d[k];
			end
		end
	end

endmodule

>>> hw/rtl/sff_mac.sv
// Coefficient multipliers and a registered adder tree over the eight lanes.
module sff_mac import sff_pkg::*; (
	input  logic     clk,
	input  sff_adv_t adv,
	input  psum_t    psum_s1 [NCOEF],
	input  coef_t    coef [NCOEF],
	output acc_t     acc_s4
);

	prod_t prod_s2 [NCOEF];
	pair_t pair_s3 [NPAIR];

	always_ff @(posedge clk) begin
		if (adv.en_s2) begin
			for (int k = 0; k < NCOEF; k++) begin
				prod_s2[k] <= $signed(psum_s1[k]) * $signed(coef[k]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv.en_s3) begin
			for (int j = 0; j < NPAIR; j++) begin
				pair_s3[j] <= PAIR_W'(prod_s2[2*j]) + PAIR_W'(prod_s2[2*j+1]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv.en_s4) begin
			acc_s4 <= (ACC_W'(pair_s3[0]) + ACC_W'(pair_s3[1])) +
				(ACC_W'(pair_s3[2]) + ACC_W'(pair_s3[3]));
		end
	end

endmodule

>>> hw/rtl/sff_round_sat.sv
// Rounding, scaling and saturation into the output register.
module sff_round_sat import sff_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    load,
	input  logic    v_s4,
	input  acc_t    acc_s4,
	output logic    result_valid,
	output result_t result_q
);

	acc_t                    rnd;
	logic signed [Q_W-1:0]   q;
	result_t                 res_d;

	// Adding half an LSB and then flooring rounds half toward plus infinity.
	assign rnd = acc_s4 + ACC_W'(ROUND_BIAS);
	assign q   = rnd[ACC_W-1:FRAC_BITS];

	always_comb begin
		if (q > SAT_MAX) begin
			res_d.filtered = OUT_MAX;
			res_d.clipped  = 1'b1;
		end else if (q < SAT_MIN) begin
			res_d.filtered = OUT_MIN;
			res_d.clipped  = 1'b1;
		end else begin
			res_d.filtered = q[SAMPLE_W-1:0];
			res_d.clipped  = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (load) begin
			result_valid <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			result_q <= res_d;
		end
	end

	a_clip_rail: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_q.clipped |->
			(result_q.filtered == OUT_MAX || result_q.filtered == OUT_MIN))
		else $error("clipped result is not at a rail");

endmodule

>>> hw/rtl/symmetric_fir_filter_top.sv
// Top level of the symmetric FIR filter: coefficient registers and pipeline control.
//
//  Channel   Signals                                  Role
//  -------   --------------------------------------   ----------------------------
//  sample    sample_valid, sample_ready, sample_data   request: sample, start_req
//  result    result_valid, result_ready, result_data   result: filtered, clipped
//  config    cfg_we, cfg_index, cfg_wdata              coefficient writes, no wait
//
// One request is taken per cycle while sample_ready is high; its result passes
// through pre-add, multiply, two adder levels, round and saturate, each
// registered, with the pre-add register loading at the accepting edge.
// Reset clears the coefficients, the sample history and all stage valid bits.
// A stall on the result side fills empty stages first; sample_ready drops only
// when every stage holds a request.
module symmetric_fir_filter_top import sff_pkg::*; #(
	parameter int TAPS = 15
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  sample_valid,
	output logic                  sample_ready,
	input  sample_req_t           sample_data,
	output logic                  result_valid,
	input  logic                  result_ready,
	output result_t               result_data,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [COEF_W-1:0]     cfg_wdata
);

	coef_t    coef_q [NCOEF];
	logic     v_s1, v_s2, v_s3, v_s4;
	logic     en_o;
	logic     accept;
	sff_adv_t adv;
	psum_t    psum_s1 [NCOEF];
	acc_t     acc_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NCOEF; k++) begin
				coef_q[k] <= '0;
			end
		end else if (cfg_we && cfg_index < CFG_IDX_W'(NCOEF)) begin
			coef_q[cfg_index[COEF_IDX_W-1:0]] <= cfg_wdata;
		end
	end

	// Each stage may load when it is empty or when the stage after it loads.
	assign en_o         = !result_valid || result_ready;
	assign adv.en_s4    = !v_s4 || en_o;
	assign adv.en_s3    = !v_s3 || adv.en_s4;
	assign adv.en_s2    = !v_s2 || adv.en_s3;
	assign sample_ready = !v_s1 || adv.en_s2;
	assign accept       = sample_valid && sample_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (sample_ready) begin
				v_s1 <= sample_valid;
			end
			if (adv.en_s2) begin
				v_s2 <= v_s1;
			end
			if (adv.en_s3) begin
				v_s3 <= v_s2;
			end
			if (adv.en_s4) begin
				v_s4 <= v_s3;
			end
		end
	end

	sff_delay_line #(
		.TAPS(TAPS)
	) u_delay_line (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.load    (sample_ready),
		.req     (sample_data),
		.psum_s1 (psum_s1)
	);

	sff_mac u_mac (
		.clk     (clk),
		.adv     (adv),
		.psum_s1 (psum_s1),
		.coef    (coef_q),
		.acc_s4  (acc_s4)
	);

	sff_round_sat u_round_sat (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (en_o),
		.v_s4         (v_s4),
		.acc_s4       (acc_s4),
		.result_valid (result_valid),
		.result_q     (result_data)
	);

	a_ready_full: assert property (@(posedge clk) disable iff (!arst_n)
		!sample_ready |-> v_s1 && v_s2 && v_s3 && v_s4 && result_valid)
		else $error("input stalled while a pipeline stage is empty");

	a_accept_fill: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> v_s1)
		else $error("accepted request did not enter the first stage");

	a_no_loss: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && !adv.en_s4 |=> v_s4)
		else $error("stalled request dropped from the last adder stage");

endmodule

>>> tb/sv/symmetric_fir_filter_top_tb.sv
// Self-checking testbench for the symmetric FIR filter top level.
`timescale 1ns / 100ps

module symmetric_fir_filter_top_tb;
	import sff_pkg::*;

	localparam int TAPS           = 15;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int PHASE_ITEMS    = 200;
	localparam int RANDOM_PHASES  = 8;
	localparam int NUM_INDEXES    = 1 << CFG_IDX_W;

	// Holds the coefficients and delay line as the filter sees them, and the
	// filtered samples that are still owed by the block.
	class fir_scoreboard #(int TAPS = 15);
		coef_t   coefs[NCOEF];
		sample_t history[TAPS-1];
		result_t expected_q[$];
		int      errors;

		function new();
			foreach (coefs[i]) coefs[i] = '0;
			foreach (history[i]) history[i] = '0;
			errors = 0;
		endfunction

		function void write_coef(int unsigned idx, logic [COEF_W-1:0] value);
			if (idx < NCOEF) coefs[idx] = coef_t'(value);
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function result_t filter_sample(sample_req_t req);
			sample_t taps[TAPS];
			longint  acc;
			longint  rounded;
			result_t res;
			if (req.start_req) foreach (history[i]) history[i] = '0;
			taps[0] = req.sample;
			for (int k = 1; k < TAPS; k++) taps[k] = history[k-1];
			acc = 0;
			// Mirrored taps share one coefficient, so add them before the multiply.
			for (int k = 0; k < TAPS / 2; k++)
				acc += (longint'(taps[k]) + longint'(taps[TAPS-1-k])) * longint'(coefs[k]);
			if (TAPS % 2 == 1)
				acc += longint'(taps[TAPS/2]) * longint'(coefs[TAPS/2]);
			// The arithmetic shift floors, which gives round half up with the bias.
			rounded = (acc + ROUND_BIAS) >>> FRAC_BITS;
			res.clipped = 1'b1;
			if (rounded > 32767) begin
				res.filtered = OUT_MAX;
			end else if (rounded < -32768) begin
				res.filtered = OUT_MIN;
			end else begin
				res.filtered = sample_t'(rounded);
				res.clipped  = 1'b0;
			end
			for (int k = TAPS - 2; k > 0; k--) history[k] = history[k-1];
			history[0] = req.sample;
			return res;
		endfunction

		function void note_request(sample_req_t req);
			expected_q.push_back(filter_sample(req));
		endfunction

		task report(string msg);
			$display("[%0t] mismatch: %s", $time, msg);
			errors++;
		endtask

		task check_result(result_t got);
			result_t want;
			if (expected_q.size() == 0) begin
				report($sformatf("result %0d clipped %0b with no request outstanding",
					got.filtered, got.clipped));
				return;
			end
			want = expected_q.pop_front();
			if (got.filtered !== want.filtered)
				report($sformatf("filtered got %0d expected %0d", got.filtered, want.filtered));
			if (got.clipped !== want.clipped)
				report($sformatf("clipped got %b expected %b (filtered %0d)",
					got.clipped, want.clipped, want.filtered));
		endtask
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 sample_valid;
	logic                 sample_ready;
	sample_req_t          sample_data;
	logic                 result_valid;
	logic                 result_ready;
	result_t              result_data;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [COEF_W-1:0]    cfg_wdata;

	fir_scoreboard #(TAPS) sb;
	int unsigned src_max_gap  = 13;
	int unsigned sink_max_gap = 13;
	int          quiet_cycles = 0;

	symmetric_fir_filter_top #(
		.TAPS(TAPS)
	) u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.sample_valid(sample_valid),
		.sample_ready(sample_ready),
		.sample_data (sample_data),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result_data (result_data),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (sample_valid && sample_ready) sb.note_request(sample_data);
			if (result_valid && result_ready) sb.check_result(result_data);
		end
	end

	always @(posedge clk) begin
		if ((sample_valid && sample_ready) || (result_valid && result_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("** symmetric_fir_filter_top: FAILED **");
			$finish;
		end
	end

	// Result side: a random stall before each result is taken.
	initial begin
		int unsigned gap;
		result_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			gap = $urandom_range(0, sink_max_gap);
			if (gap != 0) begin
				result_ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			result_ready <= 1'b1;
			do @(posedge clk); while (!result_valid);
			@(negedge clk);
		end
	end

	// Called at a falling edge; returns at the falling edge after acceptance
	// with valid still high.
	task automatic send_sample(input sample_t value, input logic start);
		int unsigned gap;
		gap = $urandom_range(0, src_max_gap);
		if (gap != 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		sample_valid          <= 1'b1;
		sample_data.sample    <= value;
		sample_data.start_req <= start;
		do @(posedge clk); while (!sample_ready);
		@(negedge clk);
	endtask

	// Indexes past the coefficient bank get random data and must be ignored.
	task automatic write_setting(input coef_t setting[NCOEF]);
		logic [COEF_W-1:0] value;
		for (int idx = 0; idx < NUM_INDEXES; idx++) begin
			value = (idx < NCOEF) ? setting[idx] : COEF_W'($urandom);
			cfg_we    <= 1'b1;
			cfg_index <= CFG_IDX_W'(idx);
			cfg_wdata <= value;
			sb.write_coef(idx, value);
			@(negedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	task automatic drain(input int settle);
		sample_valid <= 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (settle) @(negedge clk);
	endtask

	function automatic sample_t random_sample();
		case ($urandom_range(0, 9))
			0:       return OUT_MAX;
			1:       return OUT_MIN;
			2:       return sample_t'(int'($urandom_range(0, 511)) - 256);
			default: return sample_t'($urandom);
		endcase
	endfunction

	function automatic coef_t random_coef();
		case ($urandom_range(0, 5))
			0:       return OUT_MAX;
			1:       return OUT_MIN;
			2:       return '0;
			3:       return coef_t'($urandom);
			default: return coef_t'(int'($urandom_range(0, 8191)) - 4096);
		endcase
	endfunction

	initial begin
		coef_t setting[NCOEF];
		sb           = new();
		sample_valid = 1'b0;
		sample_data  = '0;
		cfg_we       = 1'b0;
		cfg_index    = '0;
		cfg_wdata    = '0;
		arst_n       = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Coefficients straight out of reset are zero, so every output is zero.
		send_sample(OUT_MAX, 1'b1);
		send_sample(OUT_MIN, 1'b0);
		send_sample(16'sd0, 1'b0);
		drain(8);

		// A unit first coefficient with a cleared history passes the sample
		// through the rounder: halfway values in both signs.
		foreach (setting[i]) setting[i] = '0;
		setting[0] = 16'sd1;
		write_setting(setting);
		send_sample(16'sd16384, 1'b1);
		send_sample(-16'sd16384, 1'b1);
		send_sample(-16'sd16385, 1'b1);
		send_sample(16'sd16383, 1'b1);
		send_sample(-16'sd1, 1'b1);
		send_sample(16'sd1, 1'b1);
		send_sample(OUT_MAX, 1'b0);
		drain(8);

		// Largest positive coefficients: one full-scale tap fits, two clip.
		foreach (setting[i]) setting[i] = OUT_MAX;
		write_setting(setting);
		send_sample(OUT_MAX, 1'b1);
		send_sample(OUT_MAX, 1'b0);
		send_sample(OUT_MAX, 1'b0);
		send_sample(OUT_MIN, 1'b1);
		send_sample(OUT_MIN, 1'b0);
		send_sample(16'sd0, 1'b1);
		drain(8);

		// Most negative coefficients flip the sign of the saturation.
		foreach (setting[i]) setting[i] = OUT_MIN;
		write_setting(setting);
		send_sample(OUT_MIN, 1'b1);
		send_sample(OUT_MIN, 1'b0);
		send_sample(OUT_MAX, 1'b1);
		send_sample(OUT_MAX, 1'b0);
		send_sample(OUT_MAX, 1'b0);
		drain(8);

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			src_max_gap  = ($urandom_range(0, 3) == 0) ? 0 : 13;
			sink_max_gap = ($urandom_range(0, 3) == 0) ? 0 : 13;
			foreach (setting[i]) setting[i] = random_coef();
			write_setting(setting);
			for (int n = 0; n < PHASE_ITEMS; n++)
				send_sample(random_sample(), $urandom_range(0, 19) == 0);
			drain((p == RANDOM_PHASES - 1) ? 20 : 8);
		end

		if (sb.errors == 0)
			$display("** symmetric_fir_filter_top: PASSED **");
		else
			$display("** symmetric_fir_filter_top: FAILED **");
		$finish;
	end

endmodule
